>>> rtl/core/atma_pkg.sv
// ----------------------------------------------------------------------------
// atma_pkg: shared constants for the triple moving average
// Widths of the length and delay fields, reset values and the constants that
// turn the configured delay into a window length.
// ----------------------------------------------------------------------------
package atma_pkg;

    // Window length lies in 2..66, so seven bits carry it and its neighbors.
    localparam int LEN_W = 7;
    localparam int DELAY_W = 8;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 8'd48;
    localparam logic [DELAY_W-1:0] DELAY_MIN   = 8'd6;
    localparam logic [DELAY_W-1:0] DELAY_MAX   = 8'd200;
    localparam logic [LEN_W-1:0]   LEN_RESET   = 7'd16;

    // floor(d / 3) equals (d * 171) >> 9 for every d up to 200.
    localparam int              THIRD_W     = 16;
    localparam logic [THIRD_W-1:0] THIRD_MUL = 16'd171;
    localparam int              THIRD_SHIFT = 9;

    // Indices of the first, middle and last of the three averaging stages.
    localparam logic [1:0] STAGE_FIRST = 2'd0;
    localparam logic [1:0] STAGE_MID   = 2'd1;
    localparam logic [1:0] STAGE_LAST  = 2'd2;

endpackage

>>> rtl/core/atma_if.sv
// ----------------------------------------------------------------------------
// atma_if: handshake channels of the triple moving average
// Sample input, filtered output and the delay configuration write channel.
// ----------------------------------------------------------------------------
interface atma_sample_if #(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface atma_filtered_if #(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink (input valid, input filtered, output ready);
endinterface

interface atma_cfg_if;
    import atma_pkg::*;

    logic               valid;
    logic               ready;
    logic [DELAY_W-1:0] delay_samples;

    modport source (output valid, output delay_samples, input ready);
    modport sink (input valid, input delay_samples, output ready);
endinterface

>>> rtl/core/adaptive_triple_moving_average.sv
// ----------------------------------------------------------------------------
// adaptive_triple_moving_average: three cascaded recursive moving averages
// Q16.16 samples pass through three moving averages that share one window
// length, which walks one step per item toward the configured target.
// ----------------------------------------------------------------------------
//  channel       dir   handshake          payload
//  sample_ch     in    valid / ready      sample        (signed, SAMPLE_WIDTH)
//  filtered_ch   out   valid / ready      filtered      (signed, SAMPLE_WIDTH)
//  cfg           in    valid / ready      delay_samples (8 bit, ready always high)
//
//  Every division runs on the shared two-bit-per-cycle divider. An item takes
//  three divisions and one history read when the length holds, three and no read
//  when it grows, and six divisions and two reads when it shrinks.
//  Reset sets the length to LEN_RESET and clears pointers and last output; unwritten history reads as zero.
//  A result waits in the output register while the next item is accepted;
//  the block stalls at the end of that item only if the result is still there.
// ----------------------------------------------------------------------------
module adaptive_triple_moving_average #(
    parameter int MAX_LEN      = 128,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    atma_sample_if.sink              sample_ch,
    atma_filtered_if.source          filtered_ch,
    atma_cfg_if.sink                 cfg
);
    import atma_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int NUM_W  = SW + 9;
    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int PROD_W = SW + LEN_W + 1;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_READ    = 7'b0000010,
        S_CAPTURE = 7'b0000100,
        S_LOAD    = 7'b0001000,
        S_START   = 7'b0010000,
        S_DIV     = 7'b0100000,
        S_DONE    = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [DELAY_W-1:0]   delay_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [ADDR_W-1:0]    head_reg;
    logic [CNT_W-1:0]     fill_reg;
    logic                 out_valid_reg;
    logic                 grow_reg;
    logic                 shrink_reg;
    logic                 phase_reg;
    logic [1:0]           stage_reg;

    logic signed [SW-1:0] vf_reg;
    logic signed [SW-1:0] af_reg;
    logic signed [SW-1:0] last_reg;
    logic signed [SW-1:0] x_reg;
    logic signed [SW-1:0] v_reg;
    logic signed [SW-1:0] a_reg;
    logic signed [SW-1:0] y_reg;
    logic signed [SW-1:0] xh_reg;
    logic signed [SW-1:0] vh_reg;
    logic signed [SW-1:0] ah_reg;
    logic signed [NUM_W-1:0] num_reg;

    // Target length from the configured delay.
    logic [DELAY_W-1:0] delay_cl;
    logic [THIRD_W-1:0] third_prod;
    logic [LEN_W-1:0]   target;

    always_comb
    begin
        delay_cl = delay_reg;
        if (delay_reg < DELAY_MIN)
        begin
            delay_cl = DELAY_MIN;
        end
        else if (delay_reg > DELAY_MAX)
        begin
            delay_cl = DELAY_MAX;
        end
    end

    assign third_prod = THIRD_W'(delay_cl) * THIRD_MUL;
    assign target     = third_prod[THIRD_SHIFT +: LEN_W];

    // History slot of the entry that is len-1 (first pass) or len-2 old.
    logic [LEN_W-1:0]  age;
    logic [ADDR_W:0]   slot_wide;
    logic [ADDR_W-1:0] slot;
    logic              slot_valid;
    logic [ADDR_W-1:0] head_next;

    assign age = phase_reg ? len_reg - LEN_W'(2) : len_reg - LEN_W'(1);

    always_comb
    begin
        slot_wide = {1'b0, head_reg};
        if (head_reg < ADDR_W'(age))
        begin
            slot_wide = slot_wide + (ADDR_W + 1)'(MAX_LEN);
        end
        slot_wide = slot_wide - (ADDR_W + 1)'(age);
    end

    assign slot       = slot_wide[ADDR_W-1:0];
    assign slot_valid = (fill_reg == CNT_W'(MAX_LEN)) ||
                        ((slot != '0) && (CNT_W'(slot) <= fill_reg));
    assign head_next  = (head_reg == ADDR_W'(MAX_LEN - 1)) ? '0 : head_reg + 1'b1;

    // History RAM: raw sample, first and second averages side by side.
    logic              ram_we;
    logic [3*SW-1:0]   ram_wdata;
    logic [3*SW-1:0]   ram_rdata;

    assign ram_wdata = {a_reg, v_reg, x_reg};

    atma_ram #(
        .WIDTH (3 * SW),
        .DEPTH (MAX_LEN)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_next),
        .wdata (ram_wdata),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    // Operand selection: numerator = p * m + q (q negated where it is subtracted).
    logic signed [SW-1:0]     p_sel;
    logic signed [SW-1:0]     q_sel;
    logic                     q_neg;
    logic [LEN_W-1:0]         m_sel;
    logic [LEN_W-1:0]         den_sel;
    logic signed [SW-1:0]     base_sel;
    logic signed [PROD_W-1:0] prod;
    logic signed [NUM_W-1:0]  q_ext;
    logic signed [NUM_W-1:0]  num_next;

    always_comb
    begin
        if (grow_reg)
        begin
            m_sel    = len_reg;
            q_neg    = 1'b0;
            den_sel  = len_reg + 1'b1;
            base_sel = '0;
            case (stage_reg)
                STAGE_FIRST:
                begin
                    p_sel = vf_reg;
                    q_sel = x_reg;
                end
                STAGE_MID:
                begin
                    p_sel = af_reg;
                    q_sel = v_reg;
                end
                default:
                begin
                    p_sel = last_reg;
                    q_sel = a_reg;
                end
            endcase
        end
        else if (!phase_reg)
        begin
            m_sel   = LEN_W'(1);
            q_neg   = 1'b1;
            den_sel = len_reg;
            case (stage_reg)
                STAGE_FIRST:
                begin
                    p_sel    = x_reg;
                    q_sel    = xh_reg;
                    base_sel = vf_reg;
                end
                STAGE_MID:
                begin
                    p_sel    = v_reg;
                    q_sel    = vh_reg;
                    base_sel = af_reg;
                end
                default:
                begin
                    p_sel    = a_reg;
                    q_sel    = ah_reg;
                    base_sel = last_reg;
                end
            endcase
        end
        else
        begin
            m_sel    = len_reg;
            q_neg    = 1'b1;
            den_sel  = len_reg - 1'b1;
            base_sel = '0;
            case (stage_reg)
                STAGE_FIRST:
                begin
                    p_sel = v_reg;
                    q_sel = xh_reg;
                end
                STAGE_MID:
                begin
                    p_sel = a_reg;
                    q_sel = vh_reg;
                end
                default:
                begin
                    p_sel = y_reg;
                    q_sel = ah_reg;
                end
            endcase
        end
    end

    assign prod     = p_sel * $signed({1'b0, m_sel});
    assign q_ext    = {{(NUM_W - SW){q_sel[SW-1]}}, q_sel};
    assign num_next = {{(NUM_W - PROD_W){prod[PROD_W-1]}}, prod} +
                      (q_neg ? -q_ext : q_ext);

    // Shared divider.
    logic                    div_start;
    logic                    div_done;
    logic signed [NUM_W-1:0] div_quo;

    assign div_start = (state_reg == S_START);

    atma_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_sel),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Add the base and saturate to the sample range.
    logic signed [NUM_W:0] sum;
    logic signed [SW-1:0]  res_sat;

    assign sum = {{(NUM_W + 1 - SW){base_sel[SW-1]}}, base_sel} +
                 {div_quo[NUM_W-1], div_quo};

    always_comb
    begin
        if ((&sum[NUM_W:SW-1]) || !(|sum[NUM_W:SW-1]))
        begin
            res_sat = sum[SW-1:0];
        end
        else if (sum[NUM_W])
        begin
            res_sat = {1'b1, {(SW - 1){1'b0}}};
        end
        else
        begin
            res_sat = {1'b0, {(SW - 1){1'b1}}};
        end
    end

    // Sequencer.
    logic in_fire;
    logic out_free;

    assign in_fire  = sample_ch.valid && sample_ch.ready;
    assign out_free = !out_valid_reg || filtered_ch.ready;
    assign ram_we   = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (target > len_reg) ? S_LOAD : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CAPTURE;
            end
            S_CAPTURE:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                state_next = S_START;
            end
            S_START:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (stage_reg != STAGE_LAST)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (!grow_reg && shrink_reg && !phase_reg)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            delay_reg     <= DELAY_RESET;
            len_reg       <= LEN_RESET;
            head_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            grow_reg      <= 1'b0;
            shrink_reg    <= 1'b0;
            phase_reg     <= 1'b0;
            stage_reg     <= STAGE_FIRST;
            vf_reg        <= '0;
            af_reg        <= '0;
            last_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                delay_reg <= cfg.delay_samples;
            end
            // A new result replacing the one just taken keeps valid high.
            if (filtered_ch.valid && filtered_ch.ready && !ram_we)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        grow_reg   <= target > len_reg;
                        shrink_reg <= target < len_reg;
                        phase_reg  <= 1'b0;
                        stage_reg  <= STAGE_FIRST;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (stage_reg != STAGE_LAST)
                        begin
                            stage_reg <= stage_reg + 1'b1;
                        end
                        else
                        begin
                            stage_reg <= STAGE_FIRST;
                            phase_reg <= 1'b1;
                        end
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        head_reg      <= head_next;
                        if (fill_reg != CNT_W'(MAX_LEN))
                        begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        vf_reg        <= v_reg;
                        af_reg        <= a_reg;
                        last_reg      <= y_reg;
                        out_valid_reg <= 1'b1;
                        if (grow_reg)
                        begin
                            len_reg <= len_reg + 1'b1;
                        end
                        else if (shrink_reg)
                        begin
                            len_reg <= len_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg <= sample_ch.sample;
        end
        if (state_reg == S_CAPTURE)
        begin
            // Entries never written read as zero.
            xh_reg <= slot_valid ? ram_rdata[SW-1:0]      : '0;
            vh_reg <= slot_valid ? ram_rdata[2*SW-1:SW]   : '0;
            ah_reg <= slot_valid ? ram_rdata[3*SW-1:2*SW] : '0;
        end
        if (state_reg == S_LOAD)
        begin
            num_reg <= num_next;
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            case (stage_reg)
                STAGE_FIRST: v_reg <= res_sat;
                STAGE_MID:   a_reg <= res_sat;
                default:     y_reg <= res_sat;
            endcase
        end
    end

    assign sample_ch.ready      = (state_reg == S_IDLE);
    assign cfg.ready            = 1'b1;
    assign filtered_ch.valid    = out_valid_reg;
    assign filtered_ch.filtered = last_reg;
endmodule

>>> rtl/core/atma_ram.sv
// ----------------------------------------------------------------------------
// atma_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module atma_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/core/atma_div.sv
// ----------------------------------------------------------------------------
// atma_div: iterative signed divider by the window length
// Restoring division on the magnitude, two quotient bits per cycle; the
// quotient truncates toward zero.
// ----------------------------------------------------------------------------
module atma_div #(
    parameter int NUM_W = 41
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [NUM_W-1:0]         num,
    input  logic [atma_pkg::LEN_W-1:0]      den,
    output logic                            done,
    output logic signed [NUM_W-1:0]         quo
);
    import atma_pkg::*;

    localparam int DIV_W = NUM_W + (NUM_W % 2);
    localparam int STEPS = DIV_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [LEN_W-1:0] den_reg;
    logic [LEN_W-1:0] rem_reg;
    logic [DIV_W-1:0] dvd_reg;

    logic [NUM_W-1:0] num_mag;
    logic [LEN_W-1:0] den_eff;
    logic [LEN_W-1:0] rem_next;
    logic [DIV_W-1:0] dvd_next;
    logic [NUM_W-1:0] quo_mag;

    assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    // A zero divisor is taken as one.
    assign den_eff = (den == '0) ? LEN_W'(1) : den;

    always_comb
    begin
        logic [LEN_W-1:0] r;
        logic [DIV_W-1:0] d;
        logic [LEN_W:0]   t;
        r = rem_reg;
        d = dvd_reg;
        for (int i = 0; i < 2; i++)
        begin
            t = {r, d[DIV_W-1]};
            d = {d[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, den_reg})
            begin
                t = t - {1'b0, den_reg};
                d[0] = 1'b1;
            end
            r = t[LEN_W-1:0];
        end
        rem_next = r;
        dvd_next = d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NUM_W-1];
            den_reg <= den_eff;
            rem_reg <= '0;
            dvd_reg <= DIV_W'(num_mag);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    assign quo_mag = dvd_reg[NUM_W-1:0];
    assign quo     = neg_reg ? -$signed(quo_mag) : $signed(quo_mag);
    assign done    = done_reg;
endmodule

>>> tb/adaptive_triple_moving_average_tb.sv
// ----------------------------------------------------------------------------
// adaptive_triple_moving_average_tb: self-checking bench for the smoother
// Drives Q16.16 samples through the sample channel and compares every filtered
// item against a cycle-free model of the three cascaded averages and the
// adaptive window length, or against a fixed value where a directed row gives
// one. A short directed table comes first. Random phases follow, each with its
// own delay setting and sample style. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module adaptive_triple_moving_average_tb;
    import atma_pkg::*;

    localparam int  HIST_DEPTH   = 128;
    localparam int  RANDOM_ITEMS = 1700;
    localparam int  SETTLE_CYC   = 200;
    localparam int  CYCLE_LIMIT  = 3_000_000;
    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    typedef enum logic {ROW_SAMPLE, ROW_DELAY} row_kind_t;
    typedef enum int {STYLE_FULL, STYLE_EXTREME, STYLE_SMALL, STYLE_LEVEL} sample_style_t;

    logic clk;
    logic rst_n;

    atma_sample_if #(.SAMPLE_WIDTH(32))   sample_ch ();
    atma_filtered_if #(.SAMPLE_WIDTH(32)) filtered_ch ();
    atma_cfg_if                           cfg ();

    adaptive_triple_moving_average #(
        .MAX_LEN      (HIST_DEPTH),
        .SAMPLE_WIDTH (32)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_ch   (sample_ch),
        .filtered_ch (filtered_ch),
        .cfg         (cfg)
    );

    // Model state of the filter.
    longint      raw_hist    [HIST_DEPTH];
    longint      first_hist  [HIST_DEPTH];
    longint      second_hist [HIST_DEPTH];
    int          head_idx;
    int          win_len;
    longint      last_smoothed;
    logic [7:0]  delay_reg;

    logic signed [31:0] smoothed_expected_q [$];
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;
    bit          quiet_phase;
    int          stall_left;

    // Directed stimulus table.
    row_kind_t   row_kind [$];
    logic [31:0] row_value [$];
    bit          row_has_exp [$];
    logic [31:0] row_exp [$];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint sat_q(longint v);
        if (v > longint'(32'sh7FFF_FFFF))
            return longint'(32'sh7FFF_FFFF);
        if (v < -longint'(32'sh7FFF_FFFF) - 1)
            return -longint'(32'sh7FFF_FFFF) - 1;
        return v;
    endfunction

    function automatic int hist_slot(int age);
        return (head_idx + HIST_DEPTH - (age % HIST_DEPTH)) % HIST_DEPTH;
    endfunction

    function automatic logic signed [31:0] predict_smoothed(logic signed [31:0] x_in);
        longint x, v, a, y, vf, af;
        int     d, target, len, n, s0, sb;
        x = x_in;
        d = int'(delay_reg);
        if (d < int'(DELAY_MIN))
            d = int'(DELAY_MIN);
        if (d > int'(DELAY_MAX))
            d = int'(DELAY_MAX);
        target = d / 3;
        len = win_len;
        s0 = hist_slot(0);
        vf = first_hist[s0];
        af = second_hist[s0];
        if (target > len)
        begin
            n = len + 1;
            v = sat_q((vf * len + x) / n);
            a = sat_q((af * len + v) / n);
            y = sat_q((last_smoothed * len + a) / n);
            len = n;
        end
        else
        begin
            sb = hist_slot(len - 1);
            v = sat_q(vf + (x - raw_hist[sb]) / len);
            a = sat_q(af + (v - first_hist[sb]) / len);
            y = sat_q(last_smoothed + (a - second_hist[sb]) / len);
            // Shrinking re-weights once more against the entries of age L-2.
            if (target < len)
            begin
                n = len - 1;
                sb = hist_slot(len - 2);
                v = sat_q((v * len - raw_hist[sb]) / n);
                a = sat_q((a * len - first_hist[sb]) / n);
                y = sat_q((y * len - second_hist[sb]) / n);
                len = n;
            end
        end
        head_idx = (head_idx + 1) % HIST_DEPTH;
        raw_hist[head_idx] = x;
        first_hist[head_idx] = v;
        second_hist[head_idx] = a;
        win_len = len;
        last_smoothed = y;
        return y[31:0];
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] draw_sample(sample_style_t style, logic [31:0] level);
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        case (style)
            STYLE_EXTREME:
            begin
                case ($urandom_range(0, 4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return 32'h0;
                    3: return 32'hFFFF_FFFF;
                    default: return Q_ONE;
                endcase
            end
            STYLE_SMALL:
                return $urandom_range(0, 32'h3F_FFFF) - 32'h20_0000;
            STYLE_LEVEL:
                return level + $urandom_range(0, 32'h1_FFFF) - 32'h1_0000;
            default:
                return $urandom();
        endcase
    endfunction

    task automatic add_row(row_kind_t kind, logic [31:0] value, bit has_exp,
                           logic [31:0] exp_val);
        row_kind.insert(row_kind.size(), kind);
        row_value.insert(row_value.size(), value);
        row_has_exp.insert(row_has_exp.size(), has_exp);
        row_exp.insert(row_exp.size(), exp_val);
    endtask

    task automatic send_sample(logic [31:0] x, bit has_exp, logic [31:0] exp_val);
        int gap;
        logic signed [31:0] predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            sample_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        sample_ch.valid <= 1'b1;
        sample_ch.sample <= x;
        do @(posedge clk); while (!sample_ch.ready);
        predicted = predict_smoothed(x);
        smoothed_expected_q.insert(smoothed_expected_q.size(),
                                   has_exp ? exp_val : predicted);
    endtask

    // Lets every outstanding item come out and the divider go quiet.
    task automatic drain_block();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (smoothed_expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_delay(logic [7:0] d);
        drain_block();
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.delay_samples <= d;
        do @(posedge clk); while (!cfg.ready);
        delay_reg = d;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Output side: random back-pressure, decided at the falling edge.
    initial
    begin
        filtered_ch.ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                filtered_ch.ready <= 1'b0;
            end
            else
            begin
                filtered_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && filtered_ch.valid && filtered_ch.ready)
        begin
            if (smoothed_expected_q.size() == 0)
            begin
                mismatch_cnt++;
                $display("%0t: unexpected filtered item, expected none, actual %0d",
                         $time, filtered_ch.filtered);
            end
            else
            begin
                if (filtered_ch.filtered !== smoothed_expected_q[0])
                begin
                    mismatch_cnt++;
                    $display("%0t: filtered expected %0d, actual %0d",
                             $time, smoothed_expected_q[0], filtered_ch.filtered);
                end
                void'(smoothed_expected_q.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int            sent;
        int            phase_len;
        sample_style_t style;
        logic [31:0]   level;
        logic [7:0]    pick_delay;
        logic [7:0]    edge_delays [8];

        rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.sample = '0;
        cfg.valid = 1'b0;
        cfg.delay_samples = DELAY_RESET;
        quiet_phase = 1'b0;

        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            raw_hist[i] = 0;
            first_hist[i] = 0;
            second_hist[i] = 0;
        end
        head_idx = 0;
        win_len = int'(LEN_RESET);
        last_smoothed = 0;
        delay_reg = DELAY_RESET;

        edge_delays = '{8'd0, 8'd5, 8'd6, 8'd7, 8'd199, 8'd200, 8'd201, 8'd255};

        // Zero in, zero out from reset; the full-scale step then divides by 16
        // three times with the window held at its reset length.
        add_row(ROW_SAMPLE, 32'h0, 1'b1, 32'h0);
        add_row(ROW_SAMPLE, Q_MAX, 1'b1, 32'd524287);
        add_row(ROW_SAMPLE, Q_MIN, 1'b0, 32'h0);
        add_row(ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, 32'h0);
        add_row(ROW_SAMPLE, Q_ONE, 1'b0, 32'h0);
        // A delay below the floor shrinks the window toward two.
        add_row(ROW_DELAY, 32'd0, 1'b0, 32'h0);
        add_row(ROW_SAMPLE, Q_MAX, 1'b0, 32'h0);
        add_row(ROW_SAMPLE, Q_MIN, 1'b0, 32'h0);
        add_row(ROW_SAMPLE, Q_MAX, 1'b0, 32'h0);
        add_row(ROW_SAMPLE, Q_MIN, 1'b0, 32'h0);
        // A delay above the ceiling grows it toward sixty-six.
        add_row(ROW_DELAY, 32'd255, 1'b0, 32'h0);
        add_row(ROW_SAMPLE, Q_MAX, 1'b0, 32'h0);
        add_row(ROW_SAMPLE, Q_MAX, 1'b0, 32'h0);
        add_row(ROW_SAMPLE, Q_MIN, 1'b0, 32'h0);
        add_row(ROW_SAMPLE, 32'h5555_5555, 1'b0, 32'h0);
        add_row(ROW_DELAY, 32'd6, 1'b0, 32'h0);
        add_row(ROW_SAMPLE, 32'hAAAA_AAAA, 1'b0, 32'h0);
        add_row(ROW_DELAY, 32'd200, 1'b0, 32'h0);
        add_row(ROW_SAMPLE, 32'h1234_5678, 1'b0, 32'h0);
        add_row(ROW_DELAY, 32'd48, 1'b0, 32'h0);
        add_row(ROW_SAMPLE, Q_MIN, 1'b0, 32'h0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < row_kind.size(); r++)
        begin
            if (row_kind[r] == ROW_DELAY)
                write_delay(row_value[r][7:0]);
            else
                send_sample(row_value[r], row_has_exp[r], row_exp[r]);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 3)
                pick_delay = edge_delays[$urandom_range(0, 7)];
            else
                pick_delay = $urandom_range(0, 255);
            write_delay(pick_delay);
            quiet_phase = ($urandom_range(0, 3) == 0);
            style = sample_style_t'($urandom_range(0, 3));
            level = $urandom();
            // Long enough phases let the window walk the whole range.
            phase_len = $urandom_range(10, 150);
            if (phase_len > RANDOM_ITEMS - sent)
                phase_len = RANDOM_ITEMS - sent;
            for (int i = 0; i < phase_len; i++)
            begin
                send_sample(draw_sample(style, level), 1'b0, 32'h0);
                sent++;
            end
        end

        drain_block();
        if (mismatch_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
